/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/x86ild_pkg.sv */
// Package: shared types and constants of the instruction length decoder.
`timescale 1ns / 1ps
package x86ild_pkg;

	localparam int WIN_W   = 64;
	localparam int AVAIL_W = 5;
	localparam int LEN_W   = 5;
	localparam int CLS_W   = 5;

	localparam logic [LEN_W-1:0] MAX_LEN = 5'd16;

	// mnemonic classes
	localparam logic [CLS_W-1:0] CL_UNK     = 5'd0;
	localparam logic [CLS_W-1:0] CL_INT3    = 5'd1;
	localparam logic [CLS_W-1:0] CL_NOP     = 5'd2;
	localparam logic [CLS_W-1:0] CL_RET     = 5'd3;
	localparam logic [CLS_W-1:0] CL_RETF    = 5'd4;
	localparam logic [CLS_W-1:0] CL_INT     = 5'd5;
	localparam logic [CLS_W-1:0] CL_JMP     = 5'd6;
	localparam logic [CLS_W-1:0] CL_CALL    = 5'd7;
	localparam logic [CLS_W-1:0] CL_PUSH    = 5'd8;
	localparam logic [CLS_W-1:0] CL_POP     = 5'd9;
	localparam logic [CLS_W-1:0] CL_MOV     = 5'd10;
	localparam logic [CLS_W-1:0] CL_JCC     = 5'd11;
	localparam logic [CLS_W-1:0] CL_SETCC   = 5'd12;
	localparam logic [CLS_W-1:0] CL_SYSCALL = 5'd13;
	localparam logic [CLS_W-1:0] CL_ALU0    = 5'd14;
	localparam logic [CLS_W-1:0] CL_TEST    = 5'd22;
	localparam logic [CLS_W-1:0] CL_XCHG    = 5'd23;

	// opcode bytes
	localparam logic [7:0] OP_ESC   = 8'h0F;
	localparam logic [7:0] OP_GRP5  = 8'hFF;
	localparam logic [7:0] OP_INT3  = 8'hCC;
	localparam logic [7:0] OP_NOP   = 8'h90;
	localparam logic [7:0] OP_RET   = 8'hC3;
	localparam logic [7:0] OP_RETF  = 8'hCB;
	localparam logic [7:0] OP_RETN  = 8'hC2;
	localparam logic [7:0] OP_INT   = 8'hCD;
	localparam logic [7:0] OP_JMP8  = 8'hEB;
	localparam logic [7:0] OP_JMP32 = 8'hE9;
	localparam logic [7:0] OP_CALL  = 8'hE8;
	localparam logic [7:0] OP_IMM32 = 8'h81;
	localparam logic [7:0] ESC_NOPL = 8'h1F;
	localparam logic [7:0] ESC_SYSC = 8'h05;

	typedef struct packed {
		logic [LEN_W-1:0] insn_length;
		logic [CLS_W-1:0] mnemonic_class;
		logic             fits;
	} dec_result_t;

endpackage

/* rtl/x86_instruction_length_decode_top.sv */
// Top level of the x86-64 instruction length pre-decoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Instruction length pre-decoder. Give it the first eight bytes of an
// instruction window and the count of valid bytes; it returns the length,
// a mnemonic class and a fits flag. A transaction is taken on any edge with
// start high; busy is always low, so one transaction per clock is sustained.
// Each result appears on insn_length/mnemonic_class/fits for exactly one
// cycle with done high. The accepting edge loads the input register; the
// result register then loads the output of the single-pass decode (prefix
// scan, REX, opcode and ModRM length logic).
// The receiver cannot stall; results are dropped if not captured.
// Notes:
//  - up to four legacy prefixes and one REX byte are skipped
//  - avail_bytes of 0 gives length 0, class unknown, fits low
//  - bytes beyond avail_bytes are never examined
module x86_instruction_length_decode_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [x86ild_pkg::WIN_W-1:0]        window_bytes,
	input  logic [x86ild_pkg::AVAIL_W-1:0]      avail_bytes,
	output logic                                done,
	output logic [x86ild_pkg::LEN_W-1:0]        insn_length,
	output logic [x86ild_pkg::CLS_W-1:0]        mnemonic_class,
	output logic                                fits
);

	logic                              valid_s1;
	logic [x86ild_pkg::WIN_W-1:0]      window_s1;
	logic [x86ild_pkg::AVAIL_W-1:0]    avail_s1;
	logic                              valid_s2;
	logic [x86ild_pkg::AVAIL_W-1:0]    avail_s2;
	x86ild_pkg::dec_result_t           dec_res;
	x86ild_pkg::dec_result_t           res_s2;

	// never stalls: every cycle can take a new transaction
	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			window_s1 <= window_bytes;
			avail_s1  <= avail_bytes;
		end
	end

	x86ild_decode u_decode (
		.window_bytes (window_s1),
		.avail_bytes  (avail_s1),
		.result       (dec_res)
	);

	// result register; strobe lasts one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2   <= dec_res;
			avail_s2 <= avail_s1;
		end
	end

	assign done           = valid_s2;
	assign insn_length    = res_s2.insn_length;
	assign mnemonic_class = res_s2.mnemonic_class;
	assign fits           = res_s2.fits;

	// accepted transaction reaches the input register on the next edge
	`ASSERT_NEXT(a_accept_to_s1, clk, arst_n, start && !busy, valid_s1)
	// no result unless the input register held an accepted transaction
	`ASSERT_IMPL(a_done_origin, clk, arst_n, done, $past(valid_s1))
	// zero length always means unknown class and no fit
	`ASSERT_IMPL(a_zero_len, clk, arst_n, done && insn_length == 5'd0,
		mnemonic_class == x86ild_pkg::CL_UNK && !fits)
	// fit flag agrees with the length bound and the available count
	`ASSERT_IMPL(a_fit_bound, clk, arst_n, done && fits,
		insn_length <= x86ild_pkg::MAX_LEN && insn_length <= avail_s2)

endmodule

/* rtl/x86ild_decode.sv */
// Combinational length and class decode of one instruction window.
`timescale 1ns / 1ps
module x86ild_decode (
	input  logic [x86ild_pkg::WIN_W-1:0]   window_bytes,
	input  logic [x86ild_pkg::AVAIL_W-1:0] avail_bytes,
	output x86ild_pkg::dec_result_t        result
);

	function automatic logic [7:0] byte_at(input logic [63:0] w, input logic [2:0] idx);
		byte_at = w[idx*8 +: 8];
	endfunction

	function automatic logic is_prefix(input logic [7:0] c);
		is_prefix = (c == 8'h66) || (c == 8'h67) || (c == 8'hF0) || (c == 8'hF2) ||
			(c == 8'hF3) || (c == 8'h2E) || (c == 8'h36) || (c == 8'h3E) ||
			(c == 8'h26) || (c == 8'h64) || (c == 8'h65);
	endfunction

	// opcode + modrm + displacement + one SIB byte
	function automatic logic [2:0] modrm_len(input logic [7:0] m);
		logic [2:0] n;
		n = 3'd2;
		if (m[7:6] == 2'd0 && m[2:0] == 3'd5) n = n + 3'd4;
		else if (m[7:6] == 2'd1) n = n + 3'd1;
		else if (m[7:6] == 2'd2) n = n + 3'd4;
		if (m[2:0] == 3'd4 && m[7:6] != 2'd3) n = n + 3'd1;
		modrm_len = n;
	endfunction

	logic [4:0] av;
	logic [3:0] pfx;
	logic [2:0] off0;
	logic [7:0] b0;
	logic       rex;
	logic       wide;
	logic [2:0] off;
	logic [4:0] off5;
	logic [7:0] b;
	logic [7:0] b1;
	logic [7:0] b2;
	logic       has1;
	logic       has2;
	logic [3:0] nopl_n;
	logic [4:0] len;
	logic [4:0] cls;

	assign av = avail_bytes;

	// up to four legacy prefixes, each only if the byte is available
	always_comb begin
		pfx[0] = (av > 5'd0) && is_prefix(window_bytes[7:0]);
		pfx[1] = pfx[0] && (av > 5'd1) && is_prefix(window_bytes[15:8]);
		pfx[2] = pfx[1] && (av > 5'd2) && is_prefix(window_bytes[23:16]);
		pfx[3] = pfx[2] && (av > 5'd3) && is_prefix(window_bytes[31:24]);
	end

	assign off0 = 3'(pfx[0]) + 3'(pfx[1]) + 3'(pfx[2]) + 3'(pfx[3]);
	assign b0   = byte_at(window_bytes, off0);
	assign rex  = (b0[7:4] == 4'h4);
	assign wide = rex && b0[3];
	assign off  = rex ? off0 + 3'd1 : off0;
	assign off5 = {2'b00, off};
	assign b    = byte_at(window_bytes, off);
	assign b1   = byte_at(window_bytes, off + 3'd1);
	assign b2   = byte_at(window_bytes, off + 3'd2);
	assign has1 = (off5 + 5'd1) < av;
	assign has2 = (off5 + 5'd2) < av;

	// 0F 1F length: opcode pair + modrm + SIB + displacement
	always_comb begin
		nopl_n = 4'd3;
		if (b2[2:0] == 3'd4) nopl_n = nopl_n + 4'd1;
		if (b2[7:6] == 2'd1) nopl_n = nopl_n + 4'd1;
		else if (b2[7:6] == 2'd2) nopl_n = nopl_n + 4'd4;
	end

	always_comb begin
		len = off5 + 5'd1;
		cls = x86ild_pkg::CL_UNK;
		if (av == 5'd0) begin
			len = 5'd0;
		end else if ({2'b00, off0} >= av) begin
			len = 5'd1;
		end else if (rex && off5 >= av) begin
			len = 5'd1;
		end else begin
			case (b)
				x86ild_pkg::OP_INT3: begin
					cls = x86ild_pkg::CL_INT3;
				end
				x86ild_pkg::OP_NOP: begin
					cls = x86ild_pkg::CL_NOP;
				end
				x86ild_pkg::OP_RET: begin
					cls = x86ild_pkg::CL_RET;
				end
				x86ild_pkg::OP_RETF: begin
					cls = x86ild_pkg::CL_RETF;
				end
				x86ild_pkg::OP_RETN: begin
					len = off5 + 5'd3;
					cls = x86ild_pkg::CL_RET;
				end
				x86ild_pkg::OP_INT: begin
					len = off5 + 5'd2;
					cls = x86ild_pkg::CL_INT;
				end
				x86ild_pkg::OP_JMP8: begin
					len = off5 + 5'd2;
					cls = x86ild_pkg::CL_JMP;
				end
				x86ild_pkg::OP_JMP32: begin
					len = off5 + 5'd5;
					cls = x86ild_pkg::CL_JMP;
				end
				x86ild_pkg::OP_CALL: begin
					len = off5 + 5'd5;
					cls = x86ild_pkg::CL_CALL;
				end
				x86ild_pkg::OP_GRP5: begin
					if (has1) begin
						len = off5 + 5'(modrm_len(b1));
						if (b1[5:3] == 3'd2) cls = x86ild_pkg::CL_CALL;
						else if (b1[5:3] == 3'd4) cls = x86ild_pkg::CL_JMP;
						else if (b1[5:3] == 3'd6) cls = x86ild_pkg::CL_PUSH;
					end else begin
						len = off5 + 5'd2;
					end
				end
				x86ild_pkg::OP_ESC: begin
					if (!has1) begin
						len = off5 + 5'd1;
					end else if (b1[7:4] == 4'h8) begin
						len = off5 + 5'd6;
						cls = x86ild_pkg::CL_JCC;
					end else if (b1[7:4] == 4'h9) begin
						len = off5 + 5'd3;
						cls = x86ild_pkg::CL_SETCC;
					end else if (b1 == x86ild_pkg::ESC_NOPL && has2) begin
						len = off5 + 5'(nopl_n);
						cls = x86ild_pkg::CL_NOP;
					end else if (b1 == x86ild_pkg::ESC_SYSC) begin
						len = off5 + 5'd2;
						cls = x86ild_pkg::CL_SYSCALL;
					end else begin
						len = off5 + 5'd3;
					end
				end
				default: begin
					if (b[7:3] == 5'b01010) begin
						cls = x86ild_pkg::CL_PUSH;
					end else if (b[7:3] == 5'b01011) begin
						cls = x86ild_pkg::CL_POP;
					end else if (b[7:3] == 5'b10110) begin
						len = off5 + 5'd2;
						cls = x86ild_pkg::CL_MOV;
					end else if (b[7:3] == 5'b10111) begin
						len = wide ? off5 + 5'd9 : off5 + 5'd5;
						cls = x86ild_pkg::CL_MOV;
					end else if (b[7:4] == 4'h7) begin
						len = off5 + 5'd2;
						cls = x86ild_pkg::CL_JCC;
					end else if (((b < 8'h40 && b[2:0] <= 3'd3) ||
						(b >= 8'h84 && b <= 8'h8B)) && has1) begin
						len = off5 + 5'(modrm_len(b1));
						if (b >= 8'h88) cls = x86ild_pkg::CL_MOV;
						else if (b == 8'h84 || b == 8'h85) cls = x86ild_pkg::CL_TEST;
						else if (b == 8'h86 || b == 8'h87) cls = x86ild_pkg::CL_XCHG;
						else cls = x86ild_pkg::CL_ALU0 + 5'(b[5:3]);
					end else if (b[7:2] == 6'b100000 && has1) begin
						cls = x86ild_pkg::CL_ALU0 + 5'(b1[5:3]);
						len = off5 + 5'(modrm_len(b1)) +
							((b == x86ild_pkg::OP_IMM32) ? 5'd4 : 5'd1);
					end
				end
			endcase
		end
	end

	assign result.insn_length    = len;
	assign result.mnemonic_class = cls;
	assign result.fits           = (len != 5'd0) && (len <= av);

endmodule
